/* src/lst_pkg.sv */
// ----------------------------------------------------------------------------
// lst_pkg: LCD scanline timer shared definitions
// Types and fixed constants for the scanline mode timer and its step logic.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int DOT_W   = 9;
  localparam int LINE_W  = 8;
  localparam int CYC_W   = 6;
  localparam int EN_W    = 4;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  // dots spent in OAM search and pixel transfer at the start of a line
  localparam int OAM_DOTS  = 80;
  localparam int XFER_DOTS = 172;

  // stat_en bit positions
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_COINC  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LCD_ON       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COMPARE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAT_EN      = 2'd2;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_e;

  typedef struct packed {
    logic              lcd_on;
    logic [LINE_W-1:0] line_compare;
    logic [EN_W-1:0]   stat_en;
  } cfg_t;

  typedef struct packed {
    logic [DOT_W-1:0]  dots;
    logic [LINE_W-1:0] line;
    lcd_mode_e         mode;
    logic              coinc;
  } timer_t;

  typedef struct packed {
    logic [LINE_W-1:0] current_line;
    lcd_mode_e         lcd_mode;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              draw_line;
  } result_t;

endpackage

/* src/lst_if.sv */
// ----------------------------------------------------------------------------
// lst_if: LCD scanline timer channels
// Valid/ready channels for cycle-count words in and timing words out.
// ----------------------------------------------------------------------------
interface lst_in_if;
  logic                      valid;
  logic                      ready;
  logic [lst_pkg::CYC_W-1:0] machine_cycles;

  modport source (output valid, output machine_cycles, input ready);
  modport sink   (input valid, input machine_cycles, output ready);
endinterface

interface lst_out_if;
  logic                       valid;
  logic                       ready;
  logic [lst_pkg::LINE_W-1:0] current_line;
  logic [1:0]                 lcd_mode;
  logic                       coincidence;
  logic                       vblank_irq;
  logic                       stat_irq;
  logic                       draw_line;

  modport source (output valid, output current_line, output lcd_mode,
                  output coincidence, output vblank_irq, output stat_irq,
                  output draw_line, input ready);
  modport sink   (input valid, input current_line, input lcd_mode,
                  input coincidence, input vblank_irq, input stat_irq,
                  input draw_line, output ready);
endinterface

/* src/lst_step.sv */
// ----------------------------------------------------------------------------
// lst_step: one timing step
// Mode decode, STAT/coincidence, dot countdown and line advance for one word.
// ----------------------------------------------------------------------------
module lst_step #(
  parameter int LINE_DOTS     = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153
) (
  input  lst_pkg::cfg_t                   cfg_i,
  input  lst_pkg::timer_t                 state_i,
  input  logic [lst_pkg::CYC_W-1:0]       cycles_i,
  output lst_pkg::timer_t                 state_o,
  output lst_pkg::result_t                result_o
);

  localparam int OamBound  = LINE_DOTS - lst_pkg::OAM_DOTS;
  localparam int XferBound = OamBound - lst_pkg::XFER_DOTS;
  localparam int SW = lst_pkg::DOT_W + 2;
  localparam logic signed [SW-1:0] LineDotsS = SW'(LINE_DOTS);

  logic                            decoded;
  logic                            mode_en;
  lst_pkg::lcd_mode_e              mode_dec;
  logic                            coinc_hit;
  logic signed [SW-1:0]            diff;
  logic signed [SW-1:0]            reload;
  logic [lst_pkg::LINE_W:0]        nxt_line;

  // mode decode from the counter as it stands before this step
  always_comb begin
    decoded  = 1'b0;
    mode_en  = 1'b0;
    mode_dec = state_i.mode;
    if (state_i.line >= lst_pkg::LINE_W'(VISIBLE_LINES)) begin
      decoded  = 1'b1;
      mode_dec = lst_pkg::MODE_VBLANK;
      mode_en  = cfg_i.stat_en[lst_pkg::EN_VBLANK];
    end else if (int'(state_i.dots) < LINE_DOTS) begin
      decoded = 1'b1;
      if (int'(state_i.dots) >= OamBound) begin
        mode_dec = lst_pkg::MODE_OAM;
        mode_en  = cfg_i.stat_en[lst_pkg::EN_OAM];
      end else if (int'(state_i.dots) >= XferBound) begin
        mode_dec = lst_pkg::MODE_XFER;
      end else begin
        mode_dec = lst_pkg::MODE_HBLANK;
        mode_en  = cfg_i.stat_en[lst_pkg::EN_HBLANK];
      end
    end
  end

  assign coinc_hit = (state_i.line == cfg_i.line_compare);
  assign diff      = $signed({2'b00, state_i.dots}) - $signed({3'b000, cycles_i, 2'b00});
  assign reload    = diff + LineDotsS;
  assign nxt_line  = {1'b0, state_i.line} + 9'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (!cfg_i.lcd_on) begin
      state_o.dots = lst_pkg::DOT_W'(LINE_DOTS);
      state_o.line = '0;
      state_o.mode = lst_pkg::MODE_VBLANK;
    end else begin
      if (decoded) begin
        state_o.mode = mode_dec;
        if (mode_en && (mode_dec != state_i.mode)) result_o.stat_irq = 1'b1;
      end
      state_o.coinc = coinc_hit;
      if (coinc_hit && cfg_i.stat_en[lst_pkg::EN_COINC]) result_o.stat_irq = 1'b1;

      if (diff <= 0) begin
        // line done: reload minus the overshoot, floor at zero
        state_o.dots = reload[SW-1] ? '0 : reload[lst_pkg::DOT_W-1:0];
        if (nxt_line == 9'(VISIBLE_LINES)) begin
          result_o.vblank_irq = 1'b1;
          state_o.line = nxt_line[lst_pkg::LINE_W-1:0];
        end else if (nxt_line > 9'(LAST_LINE)) begin
          result_o.draw_line = 1'b1;
          state_o.line = '0;
        end else begin
          result_o.draw_line = (nxt_line < 9'(VISIBLE_LINES));
          state_o.line = nxt_line[lst_pkg::LINE_W-1:0];
        end
      end else begin
        state_o.dots = diff[lst_pkg::DOT_W-1:0];
      end
    end
    result_o.current_line = state_o.line;
    result_o.lcd_mode     = state_o.mode;
    result_o.coincidence  = state_o.coinc;
  end

endmodule

/* src/lcd_scanline_mode_timer_unit.sv */
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer_unit: LCD scanline mode timer
// Tracks dots and lines per cycle-count word and reports mode and interrupts.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        handshake
//  in_i     in   machine_cycles                                 valid/ready
//  out_o    out  current_line, lcd_mode, coincidence,           valid/ready
//                vblank_irq, stat_irq, draw_line
//  cfg      in   cfg_idx_i, cfg_data_i                          cfg_we_i
//
//  One word per cycle sustained while out_o is not stalled; the path runs through the input
//  register, then the step logic into the result register together with the timer state.
//  Reset clears config and control; dot counter resets to LINE_DOTS.
//  A stalled output holds its word; the input register still takes one more.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer_unit #(
  parameter int LINE_DOTS     = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lst_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lst_pkg::CFG_W-1:0]         cfg_data_i,
  lst_in_if.sink                            in_i,
  lst_out_if.source                         out_o
);

  lst_pkg::cfg_t                 cfg_q;
  lst_pkg::timer_t               state_q, state_d;
  lst_pkg::result_t              res_q, res_d;
  logic                          in_valid_q;
  logic [lst_pkg::CYC_W-1:0]     in_cyc_q;
  logic                          out_valid_q;
  logic                          advance;
  logic                          fire;

  assign advance  = !out_valid_q || out_o.ready;
  assign fire     = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lst_pkg::CFG_LCD_ON:       cfg_q.lcd_on       <= cfg_data_i[0];
        lst_pkg::CFG_LINE_COMPARE: cfg_q.line_compare <= cfg_data_i;
        lst_pkg::CFG_STAT_EN:      cfg_q.stat_en      <= cfg_data_i[lst_pkg::EN_W-1:0];
        default: ;
      endcase
    end
  end

  lst_step #(
    .LINE_DOTS     (LINE_DOTS),
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE)
  ) u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .cycles_i (in_cyc_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.dots  <= lst_pkg::DOT_W'(LINE_DOTS);
      state_q.line  <= '0;
      state_q.mode  <= lst_pkg::MODE_HBLANK;
      state_q.coinc <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) out_valid_q <= in_valid_q;
      if (fire) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_cyc_q <= in_i.machine_cycles;
    if (fire) res_q <= res_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.current_line = res_q.current_line;
  assign out_o.lcd_mode     = res_q.lcd_mode;
  assign out_o.coincidence  = res_q.coincidence;
  assign out_o.vblank_irq   = res_q.vblank_irq;
  assign out_o.stat_irq     = res_q.stat_irq;
  assign out_o.draw_line    = res_q.draw_line;

  // display off forces line 0, vblank mode, quiet interrupts
  a_lcd_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !cfg_q.lcd_on |=> res_q.current_line == '0 &&
      res_q.lcd_mode == lst_pkg::MODE_VBLANK && !res_q.stat_irq &&
      !res_q.vblank_irq && !res_q.draw_line)
    else $error("display-off word not forced");

  a_dots_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(state_q.dots) <= LINE_DOTS)
    else $error("dot counter above line length");

  a_irq_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.vblank_irq && res_q.draw_line))
    else $error("vblank and draw in the same word");

  a_res_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.current_line == state_q.line &&
      res_q.lcd_mode == state_q.mode && res_q.coincidence == state_q.coinc)
    else $error("result word out of step with timer state");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_cyc_q))
    else $error("pending input word lost");

endmodule
